>>> rtl/bis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bilinear image scaler
// Request and result payloads, queue entry, config codes, coordinate mapping.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int CoordW  = 12;
  localparam int ColorW  = 8;
  localparam int SizeW   = 9;
  localparam int ScaleW  = 24;
  localparam int FracW   = 16;
  localparam int IdxW    = SizeW;            // clamped indexes stay below the size register
  localparam int PixW    = 3 * ColorW;
  localparam int ProdW   = CoordW + 1 + ScaleW;
  localparam int TW      = ProdW - 1;
  localparam int BaseW   = TW - FracW;
  localparam int CmpW    = CoordW + 1;       // holds the largest frame dimension
  localparam int HalfQ   = 1 << (FracW - 1);
  localparam int WghtW   = FracW + 1;
  localparam int RowW    = ColorW + WghtW;   // one horizontal blend term
  localparam int BlendW  = RowW + WghtW;     // full Q32 blend
  localparam int CfgIdxW = 2;
  localparam int QueueDepth = 2;

  localparam logic [WghtW-1:0]  WeightOne = WghtW'(1 << FracW);
  localparam logic [BlendW-1:0] RoundHalf = BlendW'(64'd1 << (2 * FracW - 1));

  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvScale  = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } req_t;

  typedef struct packed {
    logic              answered;
    logic [ColorW-1:0] out_red;
    logic [ColorW-1:0] out_green;
    logic [ColorW-1:0] out_blue;
  } res_t;

  typedef struct packed {
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
    logic [ScaleW-1:0] inv_scale;
  } cfg_t;

  typedef struct packed {
    logic             is_query;
    logic             wr_en;
    logic [IdxW-1:0]  x0;
    logic [IdxW-1:0]  x1;
    logic [IdxW-1:0]  y0;
    logic [IdxW-1:0]  y1;
    logic [FracW-1:0] fx;
    logic [FracW-1:0] fy;
    logic [PixW-1:0]  pixel;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0]  i0;
    logic [IdxW-1:0]  i1;
    logic [FracW-1:0] f;
  } coord_t;

  // Split a scaled Q16 coordinate into clamped neighbours and a fraction.
  function automatic coord_t map_coord(input logic [TW-1:0] t, input logic [IdxW-1:0] last_i);
    logic [TW-1:0]    u;
    logic [BaseW-1:0] b;
    logic [BaseW-1:0] last_w;
    coord_t           c;
    u      = t - TW'(HalfQ);
    b      = u[TW-1:FracW];
    last_w = BaseW'(last_i);
    if (t >= TW'(HalfQ)) begin
      c.f  = u[FracW-1:0];
      c.i0 = (b > last_w) ? last_i : b[IdxW-1:0];
      c.i1 = (b >= last_w) ? last_i : b[IdxW-1:0] + IdxW'(1);
    end else begin
      // below the first pixel center: both neighbours are column or row zero
      c.f  = t[FracW-1:0] + FracW'(HalfQ);
      c.i0 = '0;
      c.i1 = '0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bis_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/bis_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_fifo: short command queue between front and back
// Holds classified requests so that either side can stall on its own.
// ----------------------------------------------------------------------------
module bis_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bis_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output bis_pkg::entry_t      entry_o,
  output logic                 empty_o
);

  localparam int PtrW = (bis_pkg::QueueDepth > 1) ? $clog2(bis_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(bis_pkg::QueueDepth + 1);

  bis_pkg::entry_t mem_q [bis_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(bis_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(bis_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(bis_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("request popped from an empty queue");

endmodule
`default_nettype wire

>>> rtl/bis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_front: request intake and coordinate mapping
// Registers a request, scales both coordinates, then clamps neighbours and
// splits weights before handing the request to the command queue.
// ----------------------------------------------------------------------------
module bis_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire bis_pkg::req_t   req_i,
  input  wire bis_pkg::cfg_t   cfg_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output bis_pkg::entry_t      entry_o
);

  logic                          s1_v_q, s1_v_d;
  bis_pkg::req_t                 s1_req_q;
  logic                          s2_v_q, s2_v_d;
  logic [bis_pkg::TW-1:0]        s2_tx_q, s2_ty_q;
  logic                          s2_op_q;
  logic                          s2_wr_en_q;
  logic [bis_pkg::IdxW-1:0]      s2_x_q, s2_y_q;
  logic [bis_pkg::PixW-1:0]      s2_pix_q;

  logic                          accept;
  logic                          s1_adv;
  logic [bis_pkg::ProdW-1:0]     prod_x, prod_y;
  logic                          wr_en;
  logic [bis_pkg::IdxW-1:0]      last_x, last_y;
  bis_pkg::coord_t               cx, cy;
  logic                          is_query;

  assign push_o = s2_v_q && !full_i;
  assign s1_adv = s1_v_q && (!s2_v_q || push_o);
  assign busy_o = s1_v_q && !s1_adv;
  assign accept = start_i && !busy_o;

  assign prod_x = bis_pkg::ProdW'({s1_req_q.x, 1'b1}) * bis_pkg::ProdW'(cfg_i.inv_scale);
  assign prod_y = bis_pkg::ProdW'({s1_req_q.y, 1'b1}) * bis_pkg::ProdW'(cfg_i.inv_scale);
  assign wr_en  = (s1_req_q.x < bis_pkg::CoordW'(cfg_i.width)) &&
                  (s1_req_q.y < bis_pkg::CoordW'(cfg_i.height));

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_v_q;
    if (s1_adv) begin
      s2_v_d = 1'b1;
    end else if (push_o) begin
      s2_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_i;
    end
    if (s1_adv) begin
      s2_tx_q    <= prod_x[bis_pkg::ProdW-1:1];
      s2_ty_q    <= prod_y[bis_pkg::ProdW-1:1];
      s2_op_q    <= s1_req_q.op;
      s2_wr_en_q <= wr_en;
      s2_x_q     <= s1_req_q.x[bis_pkg::IdxW-1:0];
      s2_y_q     <= s1_req_q.y[bis_pkg::IdxW-1:0];
      s2_pix_q   <= {s1_req_q.red, s1_req_q.green, s1_req_q.blue};
    end
  end

  assign last_x   = cfg_i.width - bis_pkg::IdxW'(1);
  assign last_y   = cfg_i.height - bis_pkg::IdxW'(1);
  assign cx       = bis_pkg::map_coord(s2_tx_q, last_x);
  assign cy       = bis_pkg::map_coord(s2_ty_q, last_y);
  assign is_query = (s2_op_q == bis_pkg::OpQuery);

  // a write reuses the first neighbour slot for its own coordinates
  always_comb begin
    entry_o.is_query = is_query;
    entry_o.wr_en    = !is_query && s2_wr_en_q;
    entry_o.x0       = is_query ? cx.i0 : s2_x_q;
    entry_o.x1       = cx.i1;
    entry_o.y0       = is_query ? cy.i0 : s2_y_q;
    entry_o.y1       = cy.i1;
    entry_o.fx       = cx.f;
    entry_o.fy       = cy.f;
    entry_o.pixel    = s2_pix_q;
  end

endmodule
`default_nettype wire

>>> rtl/bis_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_back: frame store sequencer and blend pipeline
// Runs writes and four-neighbour reads on the single memory port, then blends
// the neighbours in two registered multiply stages.
// ----------------------------------------------------------------------------
module bis_back #(
  parameter int MAX_WIDTH = 256,
  parameter int ADDR_W    = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     empty_i,
  input  wire bis_pkg::entry_t          entry_i,
  output logic                          pop_o,
  output logic                          ram_we_o,
  output logic [ADDR_W-1:0]             ram_addr_o,
  output logic [bis_pkg::PixW-1:0]      ram_wdata_o,
  input  wire logic [bis_pkg::PixW-1:0] ram_rdata_i,
  output logic                          done_o,
  output bis_pkg::res_t                 res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRd   = 2'd1;
  localparam logic [1:0] StWr   = 2'd2;
  localparam logic [1:0] LastRd = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [1:0]                    cnt_q, cnt_d;
  bis_pkg::entry_t               cur_q;
  logic                          can_take;
  logic [bis_pkg::IdxW-1:0]      xsel, ysel;

  logic                          rd_v_q;
  logic [1:0]                    rd_k_q;
  logic [bis_pkg::PixW-1:0]      p00_q, p01_q, p10_q;

  logic                          l_v, l_ans;
  logic                          a1_v_q, a1_ans_q;
  logic [bis_pkg::FracW-1:0]     a1_fx_q, a1_fy_q;
  logic [bis_pkg::WghtW-1:0]     wx0, wx1;
  logic [bis_pkg::RowW-1:0]      top_d [3];
  logic [bis_pkg::RowW-1:0]      bot_d [3];

  logic                          a2_v_q, a2_ans_q;
  logic [bis_pkg::FracW-1:0]     a2_fy_q;
  logic [bis_pkg::RowW-1:0]      a2_top_q [3];
  logic [bis_pkg::RowW-1:0]      a2_bot_q [3];
  logic [bis_pkg::WghtW-1:0]     wy0, wy1;
  logic [bis_pkg::BlendW-1:0]    blend_r [3];
  logic [bis_pkg::ColorW-1:0]    chan [3];
  logic [bis_pkg::ColorW+1:0]    rounded [3];

  logic                          done_q;
  bis_pkg::res_t                 res_q;

  // sequencer
  assign can_take = (state_q == StIdle) || (state_q == StWr) ||
                    ((state_q == StRd) && (cnt_q == LastRd));
  assign pop_o    = can_take && !empty_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StRd:    cnt_d = cnt_q + 2'd1;
      StIdle,
      StWr:    cnt_d = '0;
      default: begin
        state_d = StIdle;
        cnt_d   = '0;
      end
    endcase
    if (can_take) begin
      cnt_d   = '0;
      state_d = empty_i ? StIdle : (entry_i.is_query ? StRd : StWr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      a1_v_q  <= 1'b0;
      a2_v_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= (state_q == StRd);
      a1_v_q  <= l_v;
      a2_v_q  <= a1_v_q;
      done_q  <= a2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  // neighbour order: top-left, top-right, bottom-left, bottom-right
  assign xsel        = cnt_q[0] ? cur_q.x1 : cur_q.x0;
  assign ysel        = cnt_q[1] ? cur_q.y1 : cur_q.y0;
  assign ram_addr_o  = ADDR_W'(ysel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xsel);
  assign ram_we_o    = (state_q == StWr) && cur_q.wr_en;
  assign ram_wdata_o = cur_q.pixel;

  always_ff @(posedge clk_i) begin
    rd_k_q <= cnt_q;
    if (rd_v_q) begin
      case (rd_k_q)
        2'd0:    p00_q <= ram_rdata_i;
        2'd1:    p01_q <= ram_rdata_i;
        2'd2:    p10_q <= ram_rdata_i;
        default: ;
      endcase
    end
  end

  // launch a result slot on the last read or on a write
  assign l_v   = ((state_q == StRd) && (cnt_q == LastRd)) || (state_q == StWr);
  assign l_ans = (state_q == StRd);

  always_ff @(posedge clk_i) begin
    a1_ans_q <= l_ans;
    a1_fx_q  <= cur_q.fx;
    a1_fy_q  <= cur_q.fy;
  end

  // horizontal blend; the bottom-right pixel comes straight from the memory
  assign wx1 = {1'b0, a1_fx_q};
  assign wx0 = bis_pkg::WeightOne - wx1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top_d[c] = bis_pkg::RowW'(p00_q[bis_pkg::ColorW*(2-c) +: bis_pkg::ColorW]) *
                 bis_pkg::RowW'(wx0) +
                 bis_pkg::RowW'(p01_q[bis_pkg::ColorW*(2-c) +: bis_pkg::ColorW]) *
                 bis_pkg::RowW'(wx1);
      bot_d[c] = bis_pkg::RowW'(p10_q[bis_pkg::ColorW*(2-c) +: bis_pkg::ColorW]) *
                 bis_pkg::RowW'(wx0) +
                 bis_pkg::RowW'(ram_rdata_i[bis_pkg::ColorW*(2-c) +: bis_pkg::ColorW]) *
                 bis_pkg::RowW'(wx1);
    end
  end

  always_ff @(posedge clk_i) begin
    a2_ans_q <= a1_ans_q;
    a2_fy_q  <= a1_fy_q;
    for (int c = 0; c < 3; c++) begin
      a2_top_q[c] <= top_d[c];
      a2_bot_q[c] <= bot_d[c];
    end
  end

  // vertical blend, round half up, saturate
  assign wy1 = {1'b0, a2_fy_q};
  assign wy0 = bis_pkg::WeightOne - wy1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend_r[c] = bis_pkg::BlendW'(a2_top_q[c]) * bis_pkg::BlendW'(wy0) +
                   bis_pkg::BlendW'(a2_bot_q[c]) * bis_pkg::BlendW'(wy1) +
                   bis_pkg::RoundHalf;
      rounded[c] = blend_r[c][bis_pkg::BlendW-1 -: (bis_pkg::ColorW + 2)];
      chan[c]    = (rounded[c] > (bis_pkg::ColorW + 2)'(255)) ? '1 :
                   rounded[c][bis_pkg::ColorW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a2_ans_q) begin
      res_q.answered  <= 1'b1;
      res_q.out_red   <= chan[0];
      res_q.out_green <= chan[1];
      res_q.out_blue  <= chan[2];
    end else begin
      res_q <= '0;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_launch_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l_v |-> ##3 done_q)
    else $error("launched request produced no result strobe");

  a_read_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd && cnt_q != LastRd) |=> (state_q == StRd))
    else $error("neighbour read burst cut short");

  a_last_read_blends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q && rd_k_q == LastRd) |-> (a1_v_q && a1_ans_q))
    else $error("last neighbour read not aligned with blend stage");

endmodule
`default_nettype wire

>>> rtl/bilinear_image_scaler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit: frame store with bilinear resampling
// Stores source pixels and answers destination pixel requests by blending
// four neighbours. Configuration sets image size and inverse scale.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the intake and coordinate registers and the
// queue, then the sequencer, the blend registers and the result register to done_o.
// Throughput: a query holds the single frame memory port for four neighbour
// reads, a write for a single write; the intake takes 1 request a cycle
// until the 2-entry queue fills. done_o is a one-cycle strobe; no stall input.
// Reset: config to width 256, height 256, inverse scale 1.0; frame store is
// not cleared and reads undefined until written.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire bis_pkg::req_t                 req_i,
  output logic                               done_o,
  output bis_pkg::res_t                      res_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bis_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bis_pkg::ScaleW-1:0]    cfg_data_i
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  logic [bis_pkg::SizeW-1:0]  src_width_q;
  logic [bis_pkg::SizeW-1:0]  src_height_q;
  logic [bis_pkg::ScaleW-1:0] inv_scale_q;
  bis_pkg::cfg_t              cfg;

  logic                       push;
  logic                       full;
  logic                       pop;
  logic                       empty;
  bis_pkg::entry_t            push_entry;
  bis_pkg::entry_t            head_entry;

  logic                       ram_we;
  logic [AddrW-1:0]           ram_addr;
  logic [bis_pkg::PixW-1:0]   ram_wdata;
  logic [bis_pkg::PixW-1:0]   ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bis_pkg::SizeW'(256);
      src_height_q <= bis_pkg::SizeW'(256);
      inv_scale_q  <= bis_pkg::ScaleW'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bis_pkg::CfgSrcWidth:  src_width_q  <= cfg_data_i[bis_pkg::SizeW-1:0];
        bis_pkg::CfgSrcHeight: src_height_q <= cfg_data_i[bis_pkg::SizeW-1:0];
        bis_pkg::CfgInvScale:  inv_scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero size acts as one, oversize saturates to the frame store limit
  always_comb begin
    if (src_width_q == '0) begin
      cfg.width = bis_pkg::SizeW'(1);
    end else if (bis_pkg::CmpW'(src_width_q) > bis_pkg::CmpW'(MAX_WIDTH)) begin
      cfg.width = bis_pkg::SizeW'(MAX_WIDTH);
    end else begin
      cfg.width = src_width_q;
    end
    if (src_height_q == '0) begin
      cfg.height = bis_pkg::SizeW'(1);
    end else if (bis_pkg::CmpW'(src_height_q) > bis_pkg::CmpW'(MAX_HEIGHT)) begin
      cfg.height = bis_pkg::SizeW'(MAX_HEIGHT);
    end else begin
      cfg.height = src_height_q;
    end
    cfg.inv_scale = inv_scale_q;
  end

  bis_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .cfg_i   (cfg),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  bis_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  bis_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  bis_ram #(
    .WIDTH (bis_pkg::PixW),
    .DEPTH (Depth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
